/* rtl/mrq_pkg.sv */
// shared types and constants for the mouse report to quadrature block
// no dependencies; imported by mrq_serial_div and the top level
`default_nettype none

package mrq_pkg;

	// widths of the stored axis state
	localparam int unsigned DIST_W   = 9;
	localparam int unsigned TOP_W    = 8;
	localparam int unsigned TICK_W   = 10;
	localparam int unsigned MOVE_W   = 8;
	localparam int unsigned BTN_W    = 3;
	localparam int unsigned CFG_IDX_W = 1;

	// default saturation of the pending distance
	localparam int unsigned DISTANCE_LIMIT_DEF = 300;

	// step period: top = (10000 / t) / 64 - 1 = (10000 / 64) / t - 1
	localparam int unsigned CLAMP_W      = 7;
	localparam int unsigned TOP_CLAMP    = 127;
	localparam int unsigned STEP_NUM     = 10000 / 64;
	localparam int unsigned DIV_W        = 8;
	localparam int unsigned DIV_CNT_W    = $clog2(DIV_W);
	localparam int unsigned IDLE_TOP     = 255;
	localparam int unsigned RATE_TOP     = 6;
	localparam int unsigned RESET_PERIOD = 1000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DPI_DIVIDE = 1'b0,
		REG_RATE_LIMIT = 1'b1
	} mrq_reg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DIV_X  = 2'd1,
		ST_DIV_Y  = 2'd2,
		ST_FINISH = 2'd3
	} mrq_state_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} mrq_div_stat_t;

	// axis state after a report item
	typedef struct packed {
		logic [DIST_W-1:0] pending;
		logic              heading;
	} mrq_axis_rep_t;

endpackage

`default_nettype wire

/* rtl/mrq_serial_div.sv */
// restoring divider, one quotient bit per cycle: STEP_NUM / divisor
// depends on mrq_pkg
`default_nettype none

module mrq_serial_div
	import mrq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [CLAMP_W-1:0] divisor,
	output mrq_div_stat_t           stat,
	output logic [DIV_W-1:0]        quotient
);

	logic [CLAMP_W-1:0]   rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [CLAMP_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CLAMP_W:0]     rem_sh;
	logic                 fits;
	logic [CLAMP_W:0]     rem_sub;

	// one shift and trial subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_W-1]};
		fits    = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= DIV_W'(STEP_NUM);
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[CLAMP_W-1:0] : rem_sh[CLAMP_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

/* rtl/mouse_report_to_quadrature_unit.sv */
// top level: mouse reports and timer ticks in, quadrature and button pins out
// depends on mrq_pkg and mrq_serial_div
//
// Input channel (in_valid / in_stall) carries one item: kind 0 is a mouse
// report (move_x, move_y, buttons_in), kind 1 is one 64 us timer tick.
// Each accepted item gives exactly one result on the output channel
// (out_valid / out_stall) holding the pin levels after that item.
// After a tick is accepted the sequencer goes straight to its finish state;
// after a report it first passes the two divide states: the step period of
// each axis comes from one shared restoring divider producing one quotient
// bit per cycle, x then y. The finish state loads the result into the output
// register and out_valid rises; the next item is taken back in idle. One
// item is in work at a time; in_stall is high from acceptance until the
// result is loaded into the output register, so the next item is taken
// while a result still waits there. When the receiver stalls, the output
// register holds its result and a finished item waits in the last state.
// Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
// always taken; cfg_ready is tied high.
// Reset clears distances, phases, timers and the internal pin levels (the output
// pin register is not reset), sets both step tops to one and both timer periods to 1000 ticks.
`default_nettype none

module mouse_report_to_quadrature_unit
	import mrq_pkg::*;
#(
	parameter int unsigned DISTANCE_LIMIT = DISTANCE_LIMIT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item input
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 kind,
	input  wire logic [MOVE_W-1:0]    move_x,
	input  wire logic [MOVE_W-1:0]    move_y,
	input  wire logic [BTN_W-1:0]     buttons_in,
	// result output
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      x_quad_a,
	output logic                      x_quad_b,
	output logic                      y_quad_a,
	output logic                      y_quad_b,
	output logic [BTN_W-1:0]          button_pins,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic                 cfg_data
);

	mrq_state_t state_q, state_nxt;

	logic dpi_q, rate_q;

	logic [DIST_W-1:0] x_dist_q, y_dist_q;
	logic              x_hdg_q, y_hdg_q;
	logic [1:0]        x_ph_q, y_ph_q;
	logic [TOP_W-1:0]  x_top_q, y_top_q;
	logic [TICK_W-1:0] x_cnt_q, y_cnt_q;
	logic [TICK_W-1:0] x_per_q, y_per_q;
	logic              xa_q, xb_q, ya_q, yb_q;
	logic [BTN_W-1:0]  btn_q;

	logic              out_valid_q;
	logic              o_xa_q, o_xb_q, o_ya_q, o_yb_q;
	logic [BTN_W-1:0]  o_btn_q;

	logic              in_acc;
	logic              out_free;
	logic              div_start;
	logic              out_load;
	logic [CLAMP_W-1:0] div_dsr;
	mrq_div_stat_t     div_stat;
	logic [DIV_W-1:0]  div_quo;

	mrq_axis_rep_t     x_rep, y_rep;
	logic [TOP_W-1:0]  top_new;
	logic [DIST_W-1:0] top_src_dist;

	logic              x_exp, y_exp;
	logic [1:0]        x_pins_nxt, y_pins_nxt;

	// distance and heading update for one axis on a report
	function automatic mrq_axis_rep_t axis_report(
		input logic [DIST_W-1:0] cur_dist,
		input logic              hdg,
		input logic [MOVE_W-1:0] mv,
		input logic              dpi
	);
		mrq_axis_rep_t     r;
		logic [MOVE_W-1:0] mag;
		logic [DIST_W:0]   sum;
		begin
			r.pending = cur_dist;
			r.heading = hdg;
			// direction change clears the pending distance
			if (!mv[MOVE_W-1] && (mv != '0) && !hdg) begin
				r.pending = '0;
				r.heading = 1'b1;
			end else if (mv[MOVE_W-1] && hdg) begin
				r.pending = '0;
				r.heading = 1'b0;
			end
			mag = mv[MOVE_W-1] ? (~mv + 1'b1) : mv;
			if (dpi) begin
				mag = {1'b0, mag[MOVE_W-1:1]};
				if (mag == '0) begin
					mag = MOVE_W'(1);
				end
			end
			sum = {1'b0, r.pending} + (DIST_W+1)'(mag);
			if (mv == '0) begin
				r.pending = '0;
			end else if (sum > (DIST_W+1)'(DISTANCE_LIMIT)) begin
				r.pending = DIST_W'(DISTANCE_LIMIT);
			end else begin
				r.pending = sum[DIST_W-1:0];
			end
			return r;
		end
	endfunction

	// clamp of the distance used for the step period
	function automatic logic [CLAMP_W-1:0] clamp_dist(input logic [DIST_W-1:0] d);
		begin
			return (d > DIST_W'(TOP_CLAMP)) ? CLAMP_W'(TOP_CLAMP) : d[CLAMP_W-1:0];
		end
	endfunction

	// pin pair after an edge in phase p: first pin rises in 0, falls in 2
	function automatic logic [1:0] pins_step(
		input logic [1:0] p,
		input logic       first,
		input logic       second
	);
		logic [1:0] r;
		begin
			r = {first, second};
			case (p)
				2'd0:    r[1] = 1'b1;
				2'd1:    r[0] = 1'b1;
				2'd2:    r[1] = 1'b0;
				2'd3:    r[0] = 1'b0;
				default: r = {first, second};
			endcase
			return r;
		end
	endfunction

	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// report-side combinational update
	always_comb begin
		x_rep = axis_report(x_dist_q, x_hdg_q, move_x, dpi_q);
		y_rep = axis_report(y_dist_q, y_hdg_q, move_y, dpi_q);
	end

	// timer expiry and pin edges
	always_comb begin
		x_exp      = x_cnt_q >= x_per_q;
		y_exp      = y_cnt_q >= y_per_q;
		x_pins_nxt = pins_step(x_ph_q, xa_q, xb_q);
		y_pins_nxt = pins_step(y_ph_q, yb_q, ya_q);
	end

	// step top from the divider result
	always_comb begin
		top_src_dist = (state_q == ST_DIV_X) ? x_dist_q : y_dist_q;
		top_new      = div_quo - 1'b1;
		if (top_src_dist == '0) begin
			top_new = TOP_W'(IDLE_TOP);
		end
		if (rate_q && (top_new < TOP_W'(RATE_TOP))) begin
			top_new = TOP_W'(RATE_TOP);
		end
	end

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nxt = kind ? ST_FINISH : ST_DIV_X;
				end
			end
			ST_DIV_X: begin
				if (div_stat.done) begin
					state_nxt = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				if (div_stat.done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		div_dsr   = clamp_dist(y_dist_q);
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				div_start = in_valid && !kind;
				div_dsr   = clamp_dist(x_rep.pending);
			end
			ST_DIV_X:  div_start = div_stat.done;
			ST_DIV_Y:  div_start = 1'b0;
			ST_FINISH: out_load  = out_free;
			default:   in_stall  = 1'b1;
		endcase
	end

	mrq_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (div_dsr),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// state register and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dpi_q   <= 1'b0;
			rate_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DPI_DIVIDE: dpi_q  <= cfg_data;
					REG_RATE_LIMIT: rate_q <= cfg_data;
					default:        dpi_q  <= dpi_q;
				endcase
			end
		end
	end

	// axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_dist_q <= '0;
			y_dist_q <= '0;
			x_hdg_q  <= 1'b0;
			y_hdg_q  <= 1'b0;
			x_ph_q   <= '0;
			y_ph_q   <= '0;
			x_top_q  <= TOP_W'(1);
			y_top_q  <= TOP_W'(1);
			x_cnt_q  <= '0;
			y_cnt_q  <= '0;
			x_per_q  <= TICK_W'(RESET_PERIOD);
			y_per_q  <= TICK_W'(RESET_PERIOD);
			xa_q     <= 1'b0;
			xb_q     <= 1'b0;
			ya_q     <= 1'b0;
			yb_q     <= 1'b0;
			btn_q    <= '0;
		end else begin
			if (in_acc && !kind) begin
				// report item
				x_dist_q <= x_rep.pending;
				x_hdg_q  <= x_rep.heading;
				y_dist_q <= y_rep.pending;
				y_hdg_q  <= y_rep.heading;
				btn_q    <= {buttons_in[0], buttons_in[1], buttons_in[2]};
			end else if (in_acc && kind) begin
				// tick item, x axis
				if (x_exp) begin
					x_cnt_q <= '0;
					if (x_dist_q != '0) begin
						{xa_q, xb_q} <= x_pins_nxt;
						x_ph_q       <= x_hdg_q ? (x_ph_q + 2'd1) : (x_ph_q - 2'd1);
						x_dist_q     <= x_dist_q - 1'b1;
					end else begin
						x_ph_q <= '0;
					end
					x_per_q <= (x_top_q == '0) ? TICK_W'(1) : TICK_W'(x_top_q);
				end else begin
					x_cnt_q <= x_cnt_q + 1'b1;
				end
				// tick item, y axis
				if (y_exp) begin
					y_cnt_q <= '0;
					if (y_dist_q != '0) begin
						{yb_q, ya_q} <= y_pins_nxt;
						y_ph_q       <= y_hdg_q ? (y_ph_q + 2'd1) : (y_ph_q - 2'd1);
						y_dist_q     <= y_dist_q - 1'b1;
					end else begin
						y_ph_q <= '0;
					end
					y_per_q <= (y_top_q == '0) ? TICK_W'(1) : TICK_W'(y_top_q);
				end else begin
					y_cnt_q <= y_cnt_q + 1'b1;
				end
			end
			// step tops from the divider
			if (div_stat.done && (state_q == ST_DIV_X)) begin
				x_top_q <= top_new;
			end
			if (div_stat.done && (state_q == ST_DIV_Y)) begin
				y_top_q <= top_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_xa_q  <= xa_q;
			o_xb_q  <= xb_q;
			o_ya_q  <= ya_q;
			o_yb_q  <= yb_q;
			o_btn_q <= btn_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign x_quad_a    = o_xa_q;
	assign x_quad_b    = o_xb_q;
	assign y_quad_a    = o_ya_q;
	assign y_quad_b    = o_yb_q;
	assign button_pins = o_btn_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an item");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside the finish state");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV_X || state_q == ST_DIV_Y))
		else $error("divider running outside a divide state");

	a_dist_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(x_dist_q <= DIST_W'(DISTANCE_LIMIT)) && (y_dist_q <= DIST_W'(DISTANCE_LIMIT)))
		else $error("pending distance above its limit");

endmodule

`default_nettype wire
